// ===== rtl/aic_pkg.sv =====
// shared types, constants and control codes for the audio input conditioner
// no dependencies; imported by the sequencer, datapath and top level
`default_nettype none

package aic_pkg;

	// block length limit and derived widths
	localparam int MAX_BLOCK = 4096;
	localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
	localparam int SUM_W     = 30;
	localparam int NUM_W     = SUM_W + 1;
	localparam int DCNT_W    = $clog2(NUM_W);

	// fixed-point constants
	localparam logic [12:0]      SLOPE_Q15 = 13'd6554;
	localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

	// register reset values
	localparam logic [14:0] HP_ALPHA_RST   = 15'd32661;
	localparam logic [14:0] GATE_THR_RST   = 15'd492;
	localparam logic [14:0] LIMIT_THR_RST  = 15'd31457;

	// register indexes
	localparam logic [1:0] REG_HP_ALPHA  = 2'd0;
	localparam logic [1:0] REG_GATE_THR  = 2'd1;
	localparam logic [1:0] REG_LIMIT_THR = 2'd2;

	// datapath operations selected by the control word
	typedef enum logic [3:0] {
		OP_LOAD,
		OP_DIFF,
		OP_MUL,
		OP_RND,
		OP_GATE,
		OP_LIMX,
		OP_LIMA,
		OP_PCM,
		OP_DIV,
		OP_OUT
	} op_t;

	// configuration register set
	typedef struct packed {
		logic [14:0] hp_alpha;
		logic [14:0] gate_threshold;
		logic [14:0] limit_threshold;
	} cfg_t;

	// sequencer to datapath
	typedef struct packed {
		op_t  op;
		logic fire;
	} dp_ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic block_more;
		logic div_more;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/audio_input_conditioner_core.sv =====
// top level: configuration registers, input and result handshakes, output register
// depends on aic_pkg, aic_sequencer and aic_datapath
`default_nettype none

// Audio input conditioner, bypass path. Each 12-bit converter sample is centred,
// passed through a one-pole DC-blocking high-pass filter, a noise gate and a
// soft-knee limiter, and given out as one 16-bit PCM value that serves both
// channels; the mean absolute level is reported on the last sample of a block
// (block_end, or after 4096 samples). A small microcoded sequencer runs one
// sample at a time through a shared datapath: an ordinary sample is loaded into
// the output register after the diff, mul, rnd, gate, limx, lima and pcm steps,
// and the next sample can be taken in the cycle after that load; a block-end
// sample adds 31 divide steps, one quotient bit per cycle, for the mean before
// the result load. The result sits in an output register, so the next sample is
// taken while the last result waits; while that result is still stalled the
// sequencer holds in its output step and takes no new sample.
// Configuration writes are always ready and should only be made while idle.
module audio_input_conditioner_core
	import aic_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample channel
	input  wire logic        sample_valid,
	output logic             sample_stall,
	input  wire logic [11:0] adc_sample,
	input  wire logic        block_end,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic signed [15:0] pcm_sample,
	output logic [15:0]      level,
	output logic             level_valid,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data
);

	cfg_t      cfg_q;
	dp_ctrl_t  ctrl;
	dp_stat_t  stat;
	logic      idle;
	logic      in_xfer;
	logic      out_blocked;
	logic      out_valid_q;
	logic signed [15:0] pcm_q;
	logic [15:0] level_q;
	logic      level_valid_q;
	logic signed [15:0] dp_pcm;
	logic [15:0] dp_level;
	logic      dp_level_ok;

	// handshakes
	assign cfg_ready    = 1'b1;
	assign sample_stall = !idle;
	assign in_xfer      = sample_valid && idle;
	assign out_blocked  = out_valid_q && result_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hp_alpha        <= HP_ALPHA_RST;
			cfg_q.gate_threshold  <= GATE_THR_RST;
			cfg_q.limit_threshold <= LIMIT_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HP_ALPHA:  cfg_q.hp_alpha        <= cfg_data;
				REG_GATE_THR:  cfg_q.gate_threshold  <= cfg_data;
				REG_LIMIT_THR: cfg_q.limit_threshold <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	aic_sequencer u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_xfer     (in_xfer),
		.out_blocked (out_blocked),
		.stat        (stat),
		.ctrl        (ctrl),
		.idle        (idle)
	);

	aic_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cfg        (cfg_q),
		.adc_sample (adc_sample),
		.block_end  (block_end),
		.stat       (stat),
		.pcm        (dp_pcm),
		.level      (dp_level),
		.level_ok   (dp_level_ok)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_OUT && ctrl.fire) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_OUT && ctrl.fire) begin
			pcm_q         <= dp_pcm;
			level_q       <= dp_level;
			level_valid_q <= dp_level_ok;
		end
	end

	assign result_valid = out_valid_q;
	assign pcm_sample   = pcm_q;
	assign level        = level_q;
	assign level_valid  = level_valid_q;

	a_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !level_valid_q) |-> (level_q == 16'd0))
		else $error("level non-zero without a finished block");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("sample taken while previous still in work");

endmodule

`default_nettype wire

// ===== rtl/aic_sequencer.sv =====
// microcode sequencer: step counter, control word table and jump logic
// depends on aic_pkg
`default_nettype none

module aic_sequencer
	import aic_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_xfer,
	input  wire logic     out_blocked,
	input  wire dp_stat_t stat,
	output dp_ctrl_t      ctrl,
	output logic          idle
);

	typedef enum logic [3:0] {
		STEP_IDLE,
		STEP_DIFF,
		STEP_MUL,
		STEP_RND,
		STEP_GATE,
		STEP_LIMX,
		STEP_LIMA,
		STEP_PCM,
		STEP_DIV,
		STEP_OUT
	} step_t;

	typedef enum logic [2:0] {
		CND_NEXT,
		CND_WAIT_IN,
		CND_BLOCK_MORE,
		CND_DIV_MORE,
		CND_OUT_BLOCKED
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} uword_t;

	step_t  pc_q;
	uword_t word;
	logic   taken;

	// control store
	always_comb begin
		unique case (pc_q)
			STEP_IDLE: word = '{OP_LOAD, CND_WAIT_IN,     STEP_IDLE, STEP_DIFF};
			STEP_DIFF: word = '{OP_DIFF, CND_NEXT,        STEP_MUL,  STEP_MUL};
			STEP_MUL:  word = '{OP_MUL,  CND_NEXT,        STEP_RND,  STEP_RND};
			STEP_RND:  word = '{OP_RND,  CND_NEXT,        STEP_GATE, STEP_GATE};
			STEP_GATE: word = '{OP_GATE, CND_NEXT,        STEP_LIMX, STEP_LIMX};
			STEP_LIMX: word = '{OP_LIMX, CND_NEXT,        STEP_LIMA, STEP_LIMA};
			STEP_LIMA: word = '{OP_LIMA, CND_NEXT,        STEP_PCM,  STEP_PCM};
			STEP_PCM:  word = '{OP_PCM,  CND_BLOCK_MORE,  STEP_OUT,  STEP_DIV};
			STEP_DIV:  word = '{OP_DIV,  CND_DIV_MORE,    STEP_DIV,  STEP_OUT};
			STEP_OUT:  word = '{OP_OUT,  CND_OUT_BLOCKED, STEP_OUT,  STEP_IDLE};
			default:   word = '{OP_LOAD, CND_NEXT,        STEP_IDLE, STEP_IDLE};
		endcase
	end

	// jump condition
	always_comb begin
		unique case (word.cond)
			CND_NEXT:        taken = 1'b1;
			CND_WAIT_IN:     taken = !in_xfer;
			CND_BLOCK_MORE:  taken = stat.block_more;
			CND_DIV_MORE:    taken = stat.div_more;
			CND_OUT_BLOCKED: taken = out_blocked;
			default:         taken = 1'b1;
		endcase
	end

	// an operation takes effect unless its step is waiting on a handshake
	always_comb begin
		ctrl.op = word.op;
		unique case (word.cond)
			CND_WAIT_IN:     ctrl.fire = in_xfer;
			CND_OUT_BLOCKED: ctrl.fire = !out_blocked;
			default:         ctrl.fire = 1'b1;
		endcase
	end

	assign idle = (pc_q == STEP_IDLE);

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= taken ? word.tgt_t : word.tgt_f;
		end
	end

	// the divide loop always ends in the output step
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_DIV && !stat.div_more) |=> (pc_q == STEP_OUT))
		else $error("divide loop did not exit to output step");

endmodule

`default_nettype wire

// ===== rtl/aic_datapath.sv =====
// datapath: high-pass filter, gate, limiter, pcm scaling, level sum and divider
// depends on aic_pkg; steered by aic_sequencer control words
`default_nettype none

module aic_datapath
	import aic_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_ctrl_t    ctrl,
	input  wire cfg_t        cfg,
	input  wire logic [11:0] adc_sample,
	input  wire logic        block_end,
	output dp_stat_t         stat,
	output logic signed [15:0] pcm,
	output logic [15:0]      level,
	output logic             level_ok
);

	// architectural state
	logic signed [11:0]  pin_q;
	logic signed [17:0]  pf_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    count_q;

	// working registers
	logic signed [11:0]  x_q;
	logic                last_q;
	logic signed [18:0]  s_q;
	logic signed [33:0]  prod_q;
	logic [17:0]         mag_q;
	logic                neg_q;
	logic                over_q;
	logic [30:0]         ext_q;
	logic signed [15:0]  pcm_q;
	logic                done_q;
	logic [NUM_W-1:0]    num_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    den_q;
	logic [DCNT_W-1:0]   dcnt_q;

	logic signed [12:0]  d_c;
	logic signed [18:0]  s_c;
	logic signed [34:0]  prod_c;
	logic [34:0]         rsum_c;
	logic [19:0]         r_c;
	logic [17:0]         y_c;
	logic [17:0]         ldiff_c;
	logic [30:0]         ext_c;
	logic [31:0]         er_c;
	logic [17:0]         lim_c;
	logic [32:0]         t_c;
	logic [17:0]         pm_c;
	logic [15:0]         pm16_c;
	logic [30:0]         sum_w;
	logic [SUM_W-1:0]    sum_new;
	logic [CNT_W-1:0]    n_c;
	logic                done_c;
	logic [CNT_W:0]      rem_sh;
	logic [CNT_W:0]      rem_dif;
	logic                ge_c;

	// filter difference and feedback sum
	always_comb begin
		d_c = {x_q[11], x_q} - {pin_q[11], pin_q};
		s_c = {pf_q[17], pf_q} + {{2{d_c[12]}}, d_c, 4'b0000};
	end

	// coefficient multiply
	assign prod_c = $signed({{16{s_q[18]}}, s_q}) * $signed({20'd0, cfg.hp_alpha});

	// round to q15 and clamp to q2.15
	always_comb begin
		rsum_c = {prod_q[33], prod_q} + 35'd16384;
		r_c    = rsum_c[34:15];
		if (r_c[19:17] == 3'b000 || r_c[19:17] == 3'b111) begin
			y_c = r_c[17:0];
		end else if (r_c[19]) begin
			y_c = 18'h20000;
		end else begin
			y_c = 18'h1FFFF;
		end
	end

	// limiter: excess above the knee scaled by the slope, rounded
	always_comb begin
		ldiff_c = mag_q - {3'b000, cfg.limit_threshold};
		ext_c   = {13'd0, ldiff_c} * {18'd0, SLOPE_Q15};
		er_c    = {1'b0, ext_q} + 32'd16384;
		lim_c   = {3'b000, cfg.limit_threshold} + {1'b0, er_c[31:15]};
	end

	// pcm scaling by 32767/32768 toward zero, saturated
	always_comb begin
		t_c    = {mag_q, 15'd0} - {15'd0, mag_q};
		pm_c   = t_c[32:15];
		pm16_c = (pm_c > 18'd32767) ? 16'd32767 : pm_c[15:0];
	end

	// level sum and block accounting
	always_comb begin
		sum_w   = {1'b0, sum_q} + {13'd0, mag_q};
		sum_new = sum_w[30] ? SUM_MAX : sum_w[SUM_W-1:0];
		n_c     = count_q + 1'b1;
		done_c  = last_q || (n_c >= CNT_W'(MAX_BLOCK));
	end

	// restoring divider, one quotient bit per step
	always_comb begin
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		ge_c    = (rem_sh >= {1'b0, den_q});
		rem_dif = rem_sh - {1'b0, den_q};
	end

	assign stat.block_more = !done_c;
	assign stat.div_more   = (dcnt_q != '0);

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q   <= '0;
			pf_q    <= '0;
			sum_q   <= '0;
			count_q <= '0;
		end else if (ctrl.fire) begin
			unique case (ctrl.op)
				OP_DIFF: pin_q <= x_q;
				OP_RND:  pf_q  <= $signed(y_c);
				OP_PCM: begin
					if (done_c) begin
						sum_q   <= '0;
						count_q <= '0;
					end else begin
						sum_q   <= sum_new;
						count_q <= n_c;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			unique case (ctrl.op)
				OP_LOAD: begin
					x_q    <= $signed({~adc_sample[11], adc_sample[10:0]});
					last_q <= block_end;
				end
				OP_DIFF: s_q    <= s_c;
				OP_MUL:  prod_q <= prod_c[33:0];
				OP_RND: begin
					mag_q <= y_c[17] ? (~y_c + 18'd1) : y_c;
					neg_q <= y_c[17];
				end
				OP_GATE: begin
					if (mag_q < {3'b000, cfg.gate_threshold}) begin
						mag_q <= '0;
					end
				end
				OP_LIMX: begin
					over_q <= (mag_q > {3'b000, cfg.limit_threshold});
					ext_q  <= ext_c;
				end
				OP_LIMA: begin
					if (over_q) begin
						mag_q <= lim_c;
					end
				end
				OP_PCM: begin
					pcm_q  <= neg_q ? $signed(16'd0 - pm16_c) : $signed(pm16_c);
					done_q <= done_c;
					num_q  <= {1'b0, sum_new} + NUM_W'(n_c >> 1);
					den_q  <= n_c;
					rem_q  <= '0;
					dcnt_q <= DCNT_W'(NUM_W - 1);
				end
				OP_DIV: begin
					rem_q  <= ge_c ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
					num_q  <= {num_q[NUM_W-2:0], ge_c};
					dcnt_q <= dcnt_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// results
	assign pcm      = pcm_q;
	assign level_ok = done_q;
	assign level    = !done_q ? 16'd0
		: ((|num_q[NUM_W-1:16]) ? 16'hFFFF : num_q[15:0]);

	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_DIV) |-> (den_q != '0))
		else $error("divider running with zero divisor");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(MAX_BLOCK))
		else $error("sample count passed block limit");

endmodule

`default_nettype wire

// ===== tb/aic_result_checker.sv =====
// result checker for the audio input conditioner: snoops the sample, result and register channels
// keeps its own fixed-point model of the filter, gate, limiter and level mean; needs aic_pkg only
`timescale 1ns / 100ps

module aic_result_checker
	import aic_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_stall,
	input  logic [11:0]        adc_sample,
	input  logic               block_end,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic signed [15:0] pcm_sample,
	input  logic [15:0]        level,
	input  logic               level_valid,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	output int                 mismatches,
	output int                 awaited
);

	typedef struct packed {
		logic signed [15:0] pcm;
		logic [15:0]        level;
		logic               level_valid;
	} cond_result_t;

	// model copy of the registers and the filter and level state
	cfg_t               regs;
	logic signed [11:0] prev_centred;
	logic signed [17:0] prev_filtered;
	logic [SUM_W-1:0]   abs_sum;
	logic [13:0]        block_count;

	cond_result_t expected_q[$];
	int           error_total = 0;

	// one sample through high-pass, gate, limiter, pcm scaling and level mean
	function automatic cond_result_t condition_sample(input logic [11:0] raw, input logic is_last);
		longint       centred, acc, filt, mag, knee, out_mag, signed_out, total, n, mean;
		cond_result_t res;

		centred = longint'(raw) - 2048;
		acc     = longint'(prev_filtered) + (centred - longint'(prev_centred)) * 16;
		filt    = (longint'(regs.hp_alpha) * acc + 16384) >>> 15;
		if (filt > 131071)
			filt = 131071;
		else if (filt < -131072)
			filt = -131072;
		prev_centred  = centred[11:0];
		prev_filtered = filt[17:0];

		// noise gate on the filtered magnitude
		mag = (filt < 0) ? -filt : filt;
		if (mag < longint'(regs.gate_threshold)) begin
			filt = 0;
			mag  = 0;
		end

		// soft knee: slope 0.2 above the limit threshold, sign kept
		knee = longint'(regs.limit_threshold);
		if (mag > knee)
			mag = knee + (((mag - knee) * longint'(SLOPE_Q15) + 16384) >>> 15);

		// scale by 32767/32768 towards zero, saturate
		out_mag = (mag * 32767) / 32768;
		if (out_mag > 32767)
			out_mag = 32767;
		signed_out = (filt < 0) ? -out_mag : out_mag;
		res.pcm    = signed_out[15:0];

		// level accumulation, saturating
		total   = longint'(abs_sum) + mag;
		abs_sum = (total > longint'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];

		// block end, either marked or forced by the block length limit
		n = longint'(block_count) + 1;
		if (is_last || n >= MAX_BLOCK) begin
			mean = (longint'(abs_sum) + n / 2) / n;
			if (mean > 65535)
				mean = 65535;
			res.level       = mean[15:0];
			res.level_valid = 1'b1;
			abs_sum         = '0;
			block_count     = '0;
		end else begin
			res.level       = '0;
			res.level_valid = 1'b0;
			block_count     = n[13:0];
		end
		return res;
	endfunction

	// snoop all three channels at each edge
	always @(posedge clk or negedge arst_n) begin : snoop
		cond_result_t want;

		if (!arst_n) begin
			regs.hp_alpha        = HP_ALPHA_RST;
			regs.gate_threshold  = GATE_THR_RST;
			regs.limit_threshold = LIMIT_THR_RST;
			prev_centred         = '0;
			prev_filtered        = '0;
			abs_sum              = '0;
			block_count          = '0;
			expected_q.delete();
		end else begin
			// result transfer against the oldest prediction
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with nothing outstanding: pcm_sample %0d, level %0d",
						pcm_sample, level);
					error_total++;
				end else begin
					want = expected_q.pop_front();
					if (pcm_sample !== want.pcm) begin
						$error("pcm_sample: expected %0d, actual %0d",
							$signed(want.pcm), pcm_sample);
						error_total++;
					end
					if (level !== want.level) begin
						$error("level: expected %0d, actual %0d", want.level, level);
						error_total++;
					end
					if (level_valid !== want.level_valid) begin
						$error("level_valid: expected %0d, actual %0d",
							want.level_valid, level_valid);
						error_total++;
					end
				end
			end

			// sample transfer
			if (sample_valid && !sample_stall)
				expected_q.push_back(condition_sample(adc_sample, block_end));

			// register write; unused index is ignored
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HP_ALPHA:  regs.hp_alpha        = cfg_data;
					REG_GATE_THR:  regs.gate_threshold  = cfg_data;
					REG_LIMIT_THR: regs.limit_threshold = cfg_data;
					default: ;
				endcase
			end
		end
		mismatches <= error_total;
		awaited    <= expected_q.size();
	end

endmodule

// ===== tb/audio_input_conditioner_core_test.sv =====
// testbench top for audio_input_conditioner_core: clock, reset, sample and register stimulus
// depends on aic_pkg, the core and aic_result_checker, which predicts and compares
`timescale 1ns / 100ps

module audio_input_conditioner_core_test;
	import aic_pkg::*;

	localparam logic [1:0] REG_UNUSED    = 2'd3;
	localparam int         RANDOM_PHASES = 8;
	localparam int         PHASE_ITEMS   = 75;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	logic [11:0]        adc_sample   = 12'd2048;
	logic               block_end    = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic signed [15:0] pcm_sample;
	logic [15:0]        level;
	logic               level_valid;
	logic               cfg_valid    = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index    = REG_HP_ALPHA;
	logic [14:0]        cfg_data     = '0;

	bit idle_on = 1'b1;
	int mismatches;
	int awaited;

	audio_input_conditioner_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.adc_sample   (adc_sample),
		.block_end    (block_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pcm_sample   (pcm_sample),
		.level        (level),
		.level_valid  (level_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	aic_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.adc_sample   (adc_sample),
		.block_end    (block_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pcm_sample   (pcm_sample),
		.level        (level),
		.level_valid  (level_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.awaited      (awaited)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure
	always @(posedge clk) begin
		result_stall <= idle_on && ($urandom_range(99) < 14);
	end

	// one sample transfer, with optional idle cycles ahead of it
	task automatic send_sample(input logic [11:0] raw, input logic is_last);
		if (idle_on) begin
			while ($urandom_range(99) < 14) begin
				sample_valid <= 1'b0;
				@(posedge clk);
			end
		end
		sample_valid <= 1'b1;
		adc_sample   <= raw;
		block_end    <= is_last;
		do
			@(posedge clk);
		while (sample_stall);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited != 0);
	endtask

	// one register write transfer
	task automatic write_reg(input logic [1:0] index, input logic [14:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// register value: extremes, small, or anywhere
	function automatic logic [14:0] pick_reg_value();
		case ($urandom_range(4))
			0:       return 15'd0;
			1:       return 15'h7fff;
			2:       return 15'($urandom_range(1000));
			default: return 15'($urandom_range(32767));
		endcase
	endfunction

	// sample shapes: full range, near zero, rails, held dc
	function automatic logic [11:0] next_raw(input logic [11:0] prev_raw);
		case ($urandom_range(9))
			0, 1, 2, 3: return 12'($urandom_range(4095));
			4, 5, 6:    return 12'($urandom_range(2088, 2008));
			7:          return $urandom_range(1) ? 12'd4095 : 12'd0;
			default:    return prev_raw;
		endcase
	endfunction

	// main stimulus
	initial begin
		logic [11:0] raw;
		int          end_odds;

		raw = 12'd2048;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: rails, full steps, single-sample block, around the gate
		send_sample(12'd2048, 1'b0);
		send_sample(12'd4095, 1'b0);
		send_sample(12'd4095, 1'b0);
		send_sample(12'd0,    1'b0);
		send_sample(12'd0,    1'b0);
		send_sample(12'd4095, 1'b0);
		send_sample(12'd2048, 1'b1);
		send_sample(12'd0,    1'b1);
		send_sample(12'd2049, 1'b0);
		send_sample(12'd2047, 1'b0);
		send_sample(12'd2079, 1'b0);
		send_sample(12'd2048, 1'b1);
		drain();

		// full feedback, gate open, knee at zero so everything is limited
		write_reg(REG_HP_ALPHA,  15'h7fff);
		write_reg(REG_GATE_THR,  15'd0);
		write_reg(REG_LIMIT_THR, 15'd0);
		send_sample(12'd4095, 1'b0);
		send_sample(12'd0,    1'b0);
		send_sample(12'd4095, 1'b0);
		send_sample(12'd2048, 1'b1);
		drain();

		// zero feedback, gate shut, knee at maximum, unused index ignored
		write_reg(REG_HP_ALPHA,  15'd0);
		write_reg(REG_GATE_THR,  15'h7fff);
		write_reg(REG_LIMIT_THR, 15'h7fff);
		write_reg(REG_UNUSED,    15'h5555);
		send_sample(12'd0,    1'b0);
		send_sample(12'd4095, 1'b0);
		send_sample(12'd1,    1'b1);
		drain();

		// random register settings and samples; one phase with no idling
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(REG_HP_ALPHA,  pick_reg_value());
			write_reg(REG_GATE_THR,  pick_reg_value());
			write_reg(REG_LIMIT_THR, pick_reg_value());
			if ($urandom_range(2) == 0)
				write_reg(REG_UNUSED, 15'($urandom_range(32767)));
			idle_on  <= (p != 3);
			end_odds  = (p == 5) ? 63 : 7;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				raw = next_raw(raw);
				send_sample(raw, $urandom_range(end_odds) == 0);
			end
			drain();
		end

		// allow for a late extra result
		repeat (60) @(posedge clk);
		if (mismatches == 0 && awaited == 0)
			$display("audio_input_conditioner_core_test OK");
		else
			$display("audio_input_conditioner_core_test NOT OK");
		$finish;
	end

	// run limit
	initial begin
		#(20_000_000);
		$display("audio_input_conditioner_core_test NOT OK");
		$finish;
	end

endmodule
